@@ rtl/core/bst_pkg.sv @@
// Shared types and constants for the bitmap slot table.
// Request kind codes, field widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package bst_pkg;

  // Field widths of the request and result items.
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 6;
  localparam int CFG_W    = 7;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  // Reset value of the managed slot count register.
  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

  // Request kinds.
  localparam logic [KIND_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_GET    = 2'd2;
  localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd3;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch a new request and restart the scan
    logic step;      // advance the scan by one slot
    logic res_load;  // capture the result and commit any table update
    logic out_load;  // move the captured result to the output register
  } bst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              add_free;
    logic              find_hit;
    logic              scan_over;
    logic              out_busy;
  } bst_stat_t;

endpackage

@@ rtl/core/bitmap_slot_table.sv @@
// Top level of the bitmap slot table: stream ports, field packing and the
// controller and datapath instances. Depends on bst_pkg, bst_ctrl and bst_dp.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  request: kind, value, slot
//   m_*       out        m_tvalid/m_tready  result: status, slot, value
//   cfg_*     in         cfg_we             managed slot count
//
// Add and find walk the managed slots one per cycle; get and remove
// address the named slot directly through the single entry memory port.
// One request is in work at a time. Reset is synchronous and frees every
// slot at once. A stalled result stays in the output register while the
// next request is worked on; that request then waits until the output
// register frees.
`timescale 1ns / 1ps

module bitmap_slot_table import bst_pkg::*; #(
  parameter int NUM_SLOTS   = 64,
  parameter int ENTRY_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // entry_value[31:0], slot_number[37:32], zeros
  input  logic [KIND_W-1:0]   s_tuser,   // req_type[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // status[0], slot_found[6:1], read_value[38:7], zero
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  bst_cmd_t           cmd;
  bst_stat_t          stat;
  logic [VALUE_W-1:0] in_value;
  logic [SLOT_W-1:0]  in_slot;
  logic               out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [VALUE_W-1:0] out_value;

  // Request field unpacking.
  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_slot  = s_tdata[VALUE_W+SLOT_W-1:VALUE_W];

  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bst_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (s_tuser),
    .in_value   (in_value),
    .in_slot    (in_slot),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_value  (out_value)
  );

  // Result field packing.
  assign m_tdata = {1'b0, out_value, out_slot, out_status};

endmodule

@@ rtl/core/bst_ram.sv @@
// Generic single-port RAM with registered read data.
// One write or read address per cycle. No dependencies.
`timescale 1ns / 1ps

module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; the read data of the addressed word is always registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/bst_dp.sv @@
// Datapath of the bitmap slot table: request registers, occupancy bitmap,
// scan counter, entry memory, result and output registers.
// Depends on bst_pkg and bst_ram.
`timescale 1ns / 1ps

module bst_dp import bst_pkg::*; #(
  parameter int NUM_SLOTS   = 64,
  parameter int ENTRY_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [SLOT_W-1:0]  in_slot,
  input  bst_cmd_t           cmd,
  output bst_stat_t          stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [VALUE_W-1:0] out_value
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int DW = (ENTRY_BYTES * 8 >= VALUE_W) ? VALUE_W : ENTRY_BYTES * 8;
  localparam int AW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int MW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]   slots_in_use;
  logic [KIND_W-1:0]  kind;
  logic [DW-1:0]      key;
  logic [SLOT_W-1:0]  slot;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      idx_d;
  logic               occ_d;
  logic               pend;
  logic [NUM_SLOTS-1:0] occ;

  logic               res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [VALUE_W-1:0] res_value;
  logic               res_status_next;
  logic [SLOT_W-1:0]  res_slot_next;
  logic [VALUE_W-1:0] res_value_next;

  logic [MW-1:0]      cfg_ext;
  logic [CW-1:0]      count_next;
  logic [IW-1:0]      idx_sel;
  logic               idx_in_range;
  logic [AW-1:0]      slot_wide;
  logic [IW-1:0]      slot_sel;
  logic               slot_ok;
  logic               add_free;
  logic               find_hit;
  logic               scan_over;
  logic               is_slot_req;
  logic [IW-1:0]      ram_addr;
  logic               ram_we;
  logic [DW-1:0]      ram_rdata;
  logic [AW-1:0]      idx_wide;
  logic [AW-1:0]      idx_d_wide;

  // Managed slot count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  // The effective count is capped at the built depth.
  always_comb begin
    cfg_ext = MW'(slots_in_use);
    if (cfg_ext > MW'(NUM_SLOTS)) begin
      count_next = CW'(NUM_SLOTS);
    end else begin
      count_next = CW'(cfg_ext);
    end
  end

  // Request registers, latched when a request is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind  <= in_kind;
      key   <= in_value[DW-1:0];
      slot  <= in_slot;
      count <= count_next;
    end
  end

  // Slot decode and range checks.
  assign idx_in_range = idx < count;
  assign idx_sel      = idx[IW-1:0];
  assign slot_wide    = AW'(slot);
  assign slot_sel     = slot_wide[IW-1:0];
  assign slot_ok      = (MW'(slot) < MW'(count)) && occ[slot_sel];
  assign is_slot_req  = (kind == REQ_GET) || (kind == REQ_REMOVE);

  // Scan conditions. Find compares the word read in the previous step.
  assign add_free  = idx_in_range && !occ[idx_sel];
  assign find_hit  = pend && occ_d && (ram_rdata == key);
  assign scan_over = !idx_in_range && !pend;

  // Scan counter and the compare stage, which trails the memory read by one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (cmd.load) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (cmd.step) begin
      if (idx_in_range) begin
        idx  <= idx + CW'(1);
        pend <= (kind == REQ_FIND);
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      idx_d <= idx_sel;
      occ_d <= occ[idx_sel];
    end
  end

  // Entry memory: slot requests address the named slot, scans the counter.
  assign ram_addr = is_slot_req ? slot_sel : idx_sel;
  assign ram_we   = cmd.res_load && (kind == REQ_ADD) && add_free;

  bst_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (key),
    .rdata (ram_rdata)
  );

  // Occupancy bitmap: add sets the chosen slot, a successful remove clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.res_load) begin
      if ((kind == REQ_ADD) && add_free) begin
        occ[idx_sel] <= 1'b1;
      end else if ((kind == REQ_REMOVE) && slot_ok) begin
        occ[slot_sel] <= 1'b0;
      end
    end
  end

  // Result selection by request kind.
  assign idx_wide   = AW'(idx_sel);
  assign idx_d_wide = AW'(idx_d);

  always_comb begin
    res_status_next = STATUS_FAIL;
    res_slot_next   = '0;
    res_value_next  = '0;
    unique case (kind)
      REQ_ADD: begin
        if (add_free) begin
          res_status_next = STATUS_OK;
          res_slot_next   = idx_wide[SLOT_W-1:0];
        end
      end
      REQ_FIND: begin
        if (find_hit) begin
          res_status_next = STATUS_OK;
          res_slot_next   = idx_d_wide[SLOT_W-1:0];
        end
      end
      REQ_GET: begin
        if (slot_ok) begin
          res_status_next = STATUS_OK;
          res_value_next  = VALUE_W'(ram_rdata);
        end
      end
      REQ_REMOVE: begin
        if (slot_ok) begin
          res_status_next = STATUS_OK;
        end
      end
      default: begin
        res_status_next = STATUS_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_value  <= res_value_next;
    end
  end

  // Output register: holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_value  <= res_value;
    end
  end

  // Status back to the controller.
  assign stat.kind      = kind;
  assign stat.add_free  = add_free;
  assign stat.find_hit  = find_hit;
  assign stat.scan_over = scan_over;
  assign stat.out_busy  = out_valid && !out_ready;

endmodule

@@ rtl/core/bst_ctrl.sv @@
// Controller of the bitmap slot table: sequences accept, scan or slot access,
// result capture and hand-off to the output register.
// Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_ctrl import bst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  bst_stat_t         stat,
  output bst_cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_ACCESS  = 3'd2;
  localparam logic [2:0] ST_CHECK   = 3'd3;
  localparam logic [2:0] ST_DELIVER = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.res_load = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if ((in_kind == REQ_ADD) || (in_kind == REQ_FIND)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_ACCESS;
          end
        end
      end
      ST_SCAN: begin
        if ((stat.kind == REQ_ADD) && (stat.add_free || stat.scan_over)) begin
          cmd.res_load = 1'b1;
          state_next   = ST_DELIVER;
        end else if ((stat.kind == REQ_FIND) && (stat.find_hit || stat.scan_over)) begin
          cmd.res_load = 1'b1;
          state_next   = ST_DELIVER;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_ACCESS: begin
        // The slot's word is read here and is valid in the next cycle.
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.res_load = 1'b1;
        state_next   = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
